>>> hdl/priority_task_scheduler_unit_defines.svh
// Assertion macros shared by the scheduler modules.
// Each macro expects clk and rst_n in scope.
`ifndef PRIORITY_TASK_SCHEDULER_UNIT_DEFINES_SVH
`define PRIORITY_TASK_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define PTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication.
`define PTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

>>> hdl/pts_pkg.sv
package pts_pkg;

    localparam int PTS_TASK_SLOTS = 16;

    // Operation codes
    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_DELAY  = 3'd2;
    localparam logic [2:0] OP_TICK   = 3'd3;
    localparam logic [2:0] OP_YIELD  = 3'd4;

    // Task status codes
    localparam logic [1:0] ST_READY     = 2'd0;
    localparam logic [1:0] ST_RUNNING   = 2'd1;
    localparam logic [1:0] ST_BLOCKED   = 2'd2;
    localparam logic [1:0] ST_SUSPENDED = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PREV_RD,
        S_PREV_CHK,
        S_SCAN,
        S_PICK,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic prev_rd;
        logic prev_chk;
        logic scan;
        logic pick;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic sched;      // operation needs a scheduling pass
        logic scan_more;  // scan reads still to issue
    } sts_t;

endpackage

>>> hdl/pts_ctrl.sv
`include "priority_task_scheduler_unit_defines.svh"

module pts_ctrl
    import pts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    output cmd_t cmd,
    input  sts_t sts
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = sts.sched ? S_PREV_RD : S_DONE;
            end
            S_PREV_RD:
            begin
                state_next = S_PREV_CHK;
            end
            S_PREV_CHK:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (!sts.scan_more)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        in_stall     = 1'b1;
        out_valid    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            S_EXEC:     cmd.exec     = 1'b1;
            S_PREV_RD:  cmd.prev_rd  = 1'b1;
            S_PREV_CHK: cmd.prev_chk = 1'b1;
            S_SCAN:     cmd.scan     = 1'b1;
            S_PICK:     cmd.pick     = 1'b1;
            S_DONE:     out_valid    = 1'b1;
            default:    in_stall     = 1'b1;
        endcase
    end

    `PTS_ASSERT_NEXT(a_accept_exec, in_valid && !in_stall, state_reg == S_EXEC)
    `PTS_ASSERT_NEXT(a_scan_end, state_reg == S_SCAN && !sts.scan_more, state_reg == S_PICK)
    `PTS_ASSERT_NEXT(a_pick_done, state_reg == S_PICK, out_valid)

endmodule

>>> hdl/pts_datapath.sv
`include "priority_task_scheduler_unit_defines.svh"

module pts_datapath
    import pts_pkg::*;
#(
    parameter int TASK_SLOTS = PTS_TASK_SLOTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [2:0]  operation,
    input  logic [7:0]  priority_req,
    input  logic [31:0] delay_ticks,
    output logic [3:0]  running_task,
    output logic        switch_request,
    output logic [3:0]  created_id,
    output logic        error
);

    localparam int IDX_W = $clog2(TASK_SLOTS);
    localparam int CNT_W = $clog2(TASK_SLOTS + 1);

    // Task table: one word per field, single write port, registered read
    logic [7:0]  prio_mem [TASK_SLOTS];
    logic [1:0]  stat_mem [TASK_SLOTS];
    logic [31:0] wake_mem [TASK_SLOTS];

    logic [7:0]  rd_prio_reg;
    logic [1:0]  rd_stat_reg;
    logic [31:0] rd_wake_reg;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             we_prio;
    logic             we_stat;
    logic             we_wake;
    logic [7:0]       wr_prio;
    logic [1:0]       wr_stat;
    logic [31:0]      wr_wake;

    // Request latched at accept
    logic [2:0]  op_reg;
    logic [7:0]  prio_reg;
    logic [31:0] dly_reg;

    // Scheduler state
    logic [CNT_W-1:0] total_reg,     total_next;
    logic [IDX_W-1:0] run_idx_reg,   run_idx_next;
    logic             run_vld_reg,   run_vld_next;
    logic [IDX_W-1:0] idle_idx_reg,  idle_idx_next;
    logic [31:0]      tick_reg,      tick_next;

    // Scan state
    logic [IDX_W-1:0] scan_idx_reg,  scan_idx_next;
    logic [CNT_W-1:0] rem_reg,       rem_next;
    logic             eval_vld_reg,  eval_vld_next;
    logic [IDX_W-1:0] eval_idx_reg,  eval_idx_next;
    logic             found_reg,     found_next;
    logic [7:0]       best_prio_reg, best_prio_next;
    logic [IDX_W-1:0] best_idx_reg,  best_idx_next;
    logic             prev_rdy_reg,  prev_rdy_next;

    // Result registers
    logic [IDX_W-1:0] cid_reg, cid_next;
    logic             sw_reg,  sw_next;
    logic             err_reg, err_next;

    logic             full;
    logic             prev_in_table;
    logic [CNT_W-1:0] prev_inc;
    logic [CNT_W-1:0] scan_inc;
    logic             eligible;
    logic [IDX_W+3:0] run_wide;
    logic [IDX_W+3:0] cid_wide;

    assign full          = (total_reg == CNT_W'(TASK_SLOTS));
    assign prev_in_table = (CNT_W'(run_idx_reg) < total_reg);
    assign prev_inc      = CNT_W'(run_idx_reg) + CNT_W'(1);
    assign scan_inc      = CNT_W'(scan_idx_reg) + CNT_W'(1);

    assign eligible = (rd_stat_reg == ST_BLOCKED) ? (rd_wake_reg <= tick_reg)
                                                  : (rd_stat_reg != ST_SUSPENDED);

    assign rd_addr = cmd.prev_rd ? run_idx_reg : scan_idx_reg;

    always_comb
    begin
        sts.sched = 1'b0;
        case (op_reg) inside
            OP_START:                     sts.sched = 1'b1;
            OP_DELAY, OP_TICK, OP_YIELD:  sts.sched = (total_reg != '0);
            default:                      sts.sched = 1'b0;
        endcase
        sts.scan_more = (rem_reg != '0);
    end

    always_comb
    begin
        total_next     = total_reg;
        run_idx_next   = run_idx_reg;
        run_vld_next   = run_vld_reg;
        idle_idx_next  = idle_idx_reg;
        tick_next      = tick_reg;
        scan_idx_next  = scan_idx_reg;
        rem_next       = rem_reg;
        eval_vld_next  = 1'b0;
        eval_idx_next  = eval_idx_reg;
        found_next     = found_reg;
        best_prio_next = best_prio_reg;
        best_idx_next  = best_idx_reg;
        prev_rdy_next  = prev_rdy_reg;
        cid_next       = cid_reg;
        sw_next        = sw_reg;
        err_next       = err_reg;

        we_prio = 1'b0;
        we_stat = 1'b0;
        we_wake = 1'b0;
        wr_addr = total_reg[IDX_W-1:0];
        wr_prio = prio_reg;
        wr_stat = ST_READY;
        wr_wake = '0;

        if (cmd.exec)
        begin
            cid_next = '0;
            sw_next  = 1'b0;
            err_next = 1'b0;
            case (op_reg) inside
                OP_CREATE, OP_START:
                begin
                    if (full)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        we_prio    = 1'b1;
                        we_stat    = 1'b1;
                        we_wake    = 1'b1;
                        cid_next   = total_reg[IDX_W-1:0];
                        total_next = total_reg + CNT_W'(1);
                        if (op_reg == OP_START)
                        begin
                            wr_prio       = '0;
                            wr_stat       = ST_SUSPENDED;
                            idle_idx_next = total_reg[IDX_W-1:0];
                        end
                    end
                end
                OP_DELAY, OP_TICK, OP_YIELD:
                begin
                    if (op_reg == OP_TICK)
                    begin
                        tick_next = tick_reg + 32'd1;
                    end
                    if (total_reg == '0)
                    begin
                        err_next = 1'b1;
                    end
                    else if (op_reg == OP_DELAY && run_vld_reg && prev_in_table)
                    begin
                        // block the running task until its wake time
                        we_stat = 1'b1;
                        we_wake = 1'b1;
                        wr_addr = run_idx_reg;
                        wr_stat = ST_BLOCKED;
                        wr_wake = tick_reg + dly_reg;
                    end
                end
                default:
                begin
                    err_next = 1'b0;
                end
            endcase
        end

        if (cmd.prev_chk)
        begin
            // running task goes back to ready before the scan
            if (run_vld_reg && prev_in_table && rd_stat_reg == ST_RUNNING)
            begin
                we_stat = 1'b1;
                wr_addr = run_idx_reg;
                wr_stat = ST_READY;
            end
            prev_rdy_next = run_vld_reg && prev_in_table
                            && (rd_stat_reg == ST_RUNNING || rd_stat_reg == ST_READY);
            found_next = 1'b0;
            if (run_vld_reg)
            begin
                scan_idx_next = (prev_inc == total_reg) ? '0 : prev_inc[IDX_W-1:0];
                rem_next      = total_reg - CNT_W'(1);
            end
            else
            begin
                scan_idx_next = '0;
                rem_next      = total_reg;
            end
        end

        if (cmd.scan)
        begin
            if (rem_reg != '0)
            begin
                eval_vld_next = 1'b1;
                eval_idx_next = scan_idx_reg;
                rem_next      = rem_reg - CNT_W'(1);
                scan_idx_next = (scan_inc == total_reg) ? '0 : scan_inc[IDX_W-1:0];
            end
            // strict greater keeps the first one found on a tie
            if (eval_vld_reg && eligible && (!found_reg || rd_prio_reg > best_prio_reg))
            begin
                found_next     = 1'b1;
                best_prio_next = rd_prio_reg;
                best_idx_next  = eval_idx_reg;
            end
        end

        if (cmd.pick)
        begin
            if (found_reg)
            begin
                run_idx_next = best_idx_reg;
                we_stat      = 1'b1;
                wr_addr      = best_idx_reg;
                wr_stat      = ST_RUNNING;
            end
            else if (prev_rdy_reg)
            begin
                run_idx_next = run_idx_reg;
                we_stat      = 1'b1;
                wr_addr      = run_idx_reg;
                wr_stat      = ST_RUNNING;
            end
            else
            begin
                run_idx_next = idle_idx_reg;
            end
            run_vld_next = 1'b1;
            sw_next      = 1'b0;
            if (found_reg)
            begin
                sw_next = run_vld_reg && (best_idx_reg != run_idx_reg);
            end
            else if (!prev_rdy_reg)
            begin
                sw_next = run_vld_reg && (idle_idx_reg != run_idx_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_prio)
        begin
            prio_mem[wr_addr] <= wr_prio;
        end
        if (we_stat)
        begin
            stat_mem[wr_addr] <= wr_stat;
        end
        if (we_wake)
        begin
            wake_mem[wr_addr] <= wr_wake;
        end
        rd_prio_reg <= prio_mem[rd_addr];
        rd_stat_reg <= stat_mem[rd_addr];
        rd_wake_reg <= wake_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            prio_reg <= priority_req;
            dly_reg  <= delay_ticks;
        end
        eval_idx_reg  <= eval_idx_next;
        best_prio_reg <= best_prio_next;
        best_idx_reg  <= best_idx_next;
        cid_reg       <= cid_next;
        sw_reg        <= sw_next;
        err_reg       <= err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= '0;
            run_idx_reg  <= '0;
            run_vld_reg  <= 1'b0;
            idle_idx_reg <= '0;
            tick_reg     <= '0;
            scan_idx_reg <= '0;
            rem_reg      <= '0;
            eval_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
            prev_rdy_reg <= 1'b0;
        end
        else
        begin
            total_reg    <= total_next;
            run_idx_reg  <= run_idx_next;
            run_vld_reg  <= run_vld_next;
            idle_idx_reg <= idle_idx_next;
            tick_reg     <= tick_next;
            scan_idx_reg <= scan_idx_next;
            rem_reg      <= rem_next;
            eval_vld_reg <= eval_vld_next;
            found_reg    <= found_next;
            prev_rdy_reg <= prev_rdy_next;
        end
    end

    assign run_wide       = {4'b0000, run_idx_reg};
    assign cid_wide       = {4'b0000, cid_reg};
    assign running_task   = run_wide[3:0];
    assign created_id     = cid_wide[3:0];
    assign switch_request = sw_reg;
    assign error          = err_reg;

    `PTS_ASSERT_NOW(a_total_bound, 1'b1, total_reg <= CNT_W'(TASK_SLOTS))
    `PTS_ASSERT_NOW(a_run_in_table, run_vld_reg, CNT_W'(run_idx_reg) < total_reg)
    `PTS_ASSERT_NOW(a_scan_count, cmd.scan, rem_reg < total_reg || rem_reg == '0 || !run_vld_reg)

endmodule

>>> hdl/priority_task_scheduler_unit.sv
// Flow: create and unknown requests skip the scan; start always runs a scheduling pass,
//   and delay, tick and yield run one only when at least one task exists.
// Throughput: one request at a time; the next is taken the cycle after the result leaves.
//   The scan reads one table slot per cycle.
// Reset (rst_n, async, active low): no tasks, time zero, no task running; table contents
//   are left as they are and only entries below the task count are ever read.

`include "priority_task_scheduler_unit_defines.svh"

module priority_task_scheduler_unit
    import pts_pkg::*;
#(
    parameter int TASK_SLOTS = PTS_TASK_SLOTS
)
(
    input  logic        clk,
    input  logic        rst_n,

    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [7:0]  priority_req,
    input  logic [31:0] delay_ticks,

    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  running_task,
    output logic        switch_request,
    output logic [3:0]  created_id,
    output logic        error
);

    // The controller walks each scheduling request through: execute (table update, tick),
    // read back the running task's status, circular scan with one slot read
    // per cycle, pick the winner, then hold the result until taken.
    cmd_t cmd;
    sts_t sts;

    pts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Task table, tick counter, scan pipeline and result registers.
    pts_datapath #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .operation      (operation),
        .priority_req   (priority_req),
        .delay_ticks    (delay_ticks),
        .running_task   (running_task),
        .switch_request (switch_request),
        .created_id     (created_id),
        .error          (error)
    );

endmodule
